// ===== hdl/cwsc_pkg.sv =====
// ============================================================================
// cwsc_pkg
// shared types and constants of the collation weight string compare block
// ============================================================================
`default_nettype none

package cwsc_pkg;

    // weight table geometry
    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_WIDTH  = 8;

    // bit of a weight that marks a space-like character
    localparam int SPACE_BIT = 0;

    // stream word widths
    localparam int IN_DATA_WIDTH  = 80;
    localparam int IN_USER_WIDTH  = 2;
    localparam int OUT_DATA_WIDTH = 40;
    localparam int DIFF_WIDTH     = 32;
    localparam int LIMIT_WIDTH    = 16;

    // commands carried on tuser
    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_START = 2'd1,
        CMD_OFFER = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    // comparison modes
    typedef enum logic [1:0] {
        MODE_PLAIN  = 2'd0,
        MODE_LIMIT  = 2'd1,
        MODE_TRIM   = 2'd2,
        MODE_IGNORE = 2'd3
    } t_mode;

    // comparison phases
    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_LEAD_START = 3'd1,
        PH_LEAD       = 3'd2,
        PH_MATCH      = 3'd3,
        PH_TAIL       = 3'd4
    } t_phase;

endpackage

`default_nettype wire

// ===== hdl/cwsc_ram.sv =====
// ============================================================================
// cwsc_ram
// generic single-write, single-read ram with registered read data
// ============================================================================
`default_nettype none

module cwsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/collation_weight_string_compare_top.sv =====
// ============================================================================
// collation_weight_string_compare_top
// compares two zero-terminated byte strings through a loaded weight table
// ============================================================================
//
//  channel  | dir | tdata fields (lsb first)                       | tuser
//  ---------+-----+------------------------------------------------+------
//  s (in)   | in  | entry_index, entry_weight, compare_mode,       | cmd
//           |     | length_limit, byte_a, byte_b                   |
//  m (out)  | out | took_a, took_b, finished, difference           | -
//
//  one word per cycle sustained while the output is not stalled; each input word
//  gives one output word, registered by the table read and then by the compare step
//  the table sits in two copies of a 256-entry ram, one read port per string,
//  both written by a write command, so both heads are looked up together
//  the step registers (phase, held and saved weights, pair count) are
//  updated once per word in the second stage, so words follow back to back
//  a stalled output holds the second stage and drops s tready; the ram read
//  is enabled only on acceptance so the looked-up weights stay put
//  reset clears the phase to idle and the step registers; the table keeps
//  whatever it holds and needs no clearing pass
//
`default_nettype none

module collation_weight_string_compare_top #(
    parameter int WEIGHT_WIDTH = 32
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // input stream
    input  wire logic                                  i_s_tvalid,
    output logic                                       o_s_tready,
    // entry_index[7:0], entry_weight[39:8], compare_mode[41:40],
    // length_limit[57:42], byte_a[65:58], byte_b[73:66], zero pad
    input  wire logic [cwsc_pkg::IN_DATA_WIDTH-1:0]    i_s_tdata,
    // cmd[1:0]
    input  wire logic [cwsc_pkg::IN_USER_WIDTH-1:0]    i_s_tuser,
    // output stream
    output logic                                       o_m_tvalid,
    input  wire logic                                  i_m_tready,
    // took_a[0], took_b[1], finished[2], difference[34:3], zero pad
    output logic      [cwsc_pkg::OUT_DATA_WIDTH-1:0]   o_m_tdata
);

    import cwsc_pkg::*;

    // ------------------------------------------------------------------
    // input word unpacking
    // ------------------------------------------------------------------
    t_cmd                    in_cmd;
    logic [ADDR_WIDTH-1:0]   in_index;
    logic [31:0]             in_weight;
    t_mode                   in_mode;
    logic [LIMIT_WIDTH-1:0]  in_limit;
    logic [7:0]              in_byte_a;
    logic [7:0]              in_byte_b;

    assign in_cmd    = t_cmd'(i_s_tuser[1:0]);
    assign in_index  = i_s_tdata[7:0];
    assign in_weight = i_s_tdata[39:8];
    assign in_mode   = t_mode'(i_s_tdata[41:40]);
    assign in_limit  = i_s_tdata[57:42];
    assign in_byte_a = i_s_tdata[65:58];
    assign in_byte_b = i_s_tdata[73:66];

    // ------------------------------------------------------------------
    // handshake: stage 1 advances when the output register is free
    // ------------------------------------------------------------------
    logic r_s1_valid;
    logic s1_advance;
    logic in_accept;

    assign s1_advance = r_s1_valid && (!o_m_tvalid || i_m_tready);
    assign o_s_tready = !r_s1_valid || s1_advance;
    assign in_accept  = i_s_tvalid && o_s_tready;

    // ------------------------------------------------------------------
    // weight table, one copy per string head
    // ------------------------------------------------------------------
    logic                    tbl_wr_en;
    logic [WEIGHT_WIDTH-1:0] tbl_wr_data;
    logic [WEIGHT_WIDTH-1:0] wa;
    logic [WEIGHT_WIDTH-1:0] wb;

    assign tbl_wr_en   = in_accept && (in_cmd == CMD_WRITE);
    assign tbl_wr_data = in_weight[WEIGHT_WIDTH-1:0];

    cwsc_ram #(
        .WIDTH (WEIGHT_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_table_a (
        .i_clk     (i_clk),
        .i_wr_en   (tbl_wr_en),
        .i_wr_addr (in_index),
        .i_wr_data (tbl_wr_data),
        .i_rd_en   (in_accept),
        .i_rd_addr (in_byte_a),
        .o_rd_data (wa)
    );

    cwsc_ram #(
        .WIDTH (WEIGHT_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_table_b (
        .i_clk     (i_clk),
        .i_wr_en   (tbl_wr_en),
        .i_wr_addr (in_index),
        .i_wr_data (tbl_wr_data),
        .i_rd_en   (in_accept),
        .i_rd_addr (in_byte_b),
        .o_rd_data (wb)
    );

    // ------------------------------------------------------------------
    // stage 1 payload, aligned with the ram read data
    // ------------------------------------------------------------------
    t_cmd                   r_s1_cmd;
    t_mode                  r_s1_mode;
    logic [LIMIT_WIDTH-1:0] r_s1_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_cmd   <= in_cmd;
            r_s1_mode  <= in_mode;
            r_s1_limit <= in_limit;
        end
    end

    // ------------------------------------------------------------------
    // comparison state
    // ------------------------------------------------------------------
    t_mode                   r_mode,    n_mode;
    t_phase                  r_phase,   n_phase;
    logic [LIMIT_WIDTH-1:0]  r_pairs,   n_pairs;
    logic [WEIGHT_WIDTH-1:0] r_held_a,  n_held_a;
    logic [WEIGHT_WIDTH-1:0] r_held_b,  n_held_b;
    logic [WEIGHT_WIDTH-1:0] r_saved_a, n_saved_a;
    logic [WEIGHT_WIDTH-1:0] r_saved_b, n_saved_b;

    // step results
    logic                    took_a;
    logic                    took_b;
    logic                    finished;
    logic [WEIGHT_WIDTH-1:0] fin_a;
    logic [WEIGHT_WIDTH-1:0] fin_b;
    logic [DIFF_WIDTH-1:0]   diff;

    // step helpers
    logic                    is_space;
    logic                    is_match;
    logic                    go_tail;
    logic                    resolve;
    logic                    stop;
    logic [LIMIT_WIDTH-1:0]  pairs_dec;
    logic [WEIGHT_WIDTH-1:0] res_a;
    logic [WEIGHT_WIDTH-1:0] res_b;

    always_comb begin
        n_mode    = r_mode;
        n_phase   = r_phase;
        n_pairs   = r_pairs;
        n_held_a  = r_held_a;
        n_held_b  = r_held_b;
        n_saved_a = r_saved_a;
        n_saved_b = r_saved_b;
        took_a    = 1'b0;
        took_b    = 1'b0;
        finished  = 1'b0;
        fin_a     = '0;
        fin_b     = '0;
        go_tail   = 1'b0;
        resolve   = 1'b0;
        stop      = 1'b0;
        pairs_dec = r_pairs - LIMIT_WIDTH'(1);
        res_a     = r_saved_a;
        res_b     = r_saved_b;
        is_space  = 1'b0;
        is_match  = 1'b0;

        case (r_s1_cmd)
            CMD_START: begin
                n_mode    = r_s1_mode;
                n_pairs   = r_s1_limit;
                n_held_a  = '0;
                n_held_b  = '0;
                n_saved_a = '0;
                n_saved_b = '0;
                n_phase   = (r_s1_mode == MODE_TRIM) ? PH_LEAD_START : PH_MATCH;
            end
            CMD_OFFER: begin
                if (r_phase != PH_IDLE) begin
                    // consume heads: both while pairing, only spaces otherwise
                    if (r_phase == PH_LEAD_START || r_phase == PH_MATCH) begin
                        n_held_a = wa;
                        n_held_b = wb;
                        took_a   = 1'b1;
                        took_b   = 1'b1;
                    end else begin
                        if (r_held_a[SPACE_BIT]) begin
                            n_held_a = wa;
                            took_a   = 1'b1;
                        end
                        if (r_held_b[SPACE_BIT]) begin
                            n_held_b = wb;
                            took_b   = 1'b1;
                        end
                    end

                    is_space = n_held_a[SPACE_BIT] || n_held_b[SPACE_BIT];
                    is_match = (n_held_a == n_held_b) && (n_held_b != '0);

                    case (r_phase)
                        PH_LEAD_START, PH_LEAD: begin
                            if (is_space) begin
                                n_phase = PH_LEAD;
                            end else if (is_match) begin
                                n_phase = PH_MATCH;
                            end else begin
                                go_tail = 1'b1;
                            end
                        end
                        PH_TAIL: begin
                            resolve = 1'b1;
                        end
                        PH_MATCH: begin
                            if (r_mode == MODE_TRIM || r_mode == MODE_IGNORE) begin
                                go_tail = !is_match;
                            end else begin
                                stop = !is_match;
                                if (!stop && r_mode == MODE_LIMIT && r_pairs != '0) begin
                                    n_pairs = pairs_dec;
                                    stop    = (pairs_dec == '0);
                                end
                                if (stop) begin
                                    finished = 1'b1;
                                    fin_a    = n_held_a;
                                    fin_b    = n_held_b;
                                    n_phase  = PH_IDLE;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase

                    // mismatch: remember the weights and follow any spaces
                    if (go_tail) begin
                        n_saved_a = n_held_a;
                        n_saved_b = n_held_b;
                        res_a     = n_held_a;
                        res_b     = n_held_b;
                        n_phase   = PH_TAIL;
                        resolve   = 1'b1;
                    end

                    if (resolve && !is_space) begin
                        if (r_mode == MODE_TRIM) begin
                            // a space run that ends the string counts as its end
                            finished = 1'b1;
                            fin_a    = (n_held_a != '0) ? res_a : '0;
                            fin_b    = (n_held_b != '0) ? res_b : '0;
                            n_phase  = PH_IDLE;
                        end else if (!is_match) begin
                            finished = 1'b1;
                            fin_a    = n_held_a;
                            fin_b    = n_held_b;
                            n_phase  = PH_IDLE;
                        end else begin
                            n_phase  = PH_MATCH;
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        diff = finished ? (DIFF_WIDTH'(fin_a) - DIFF_WIDTH'(fin_b)) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_PLAIN;
            r_phase   <= PH_IDLE;
            r_pairs   <= '0;
            r_held_a  <= '0;
            r_held_b  <= '0;
            r_saved_a <= '0;
            r_saved_b <= '0;
        end else if (s1_advance) begin
            r_mode    <= n_mode;
            r_phase   <= n_phase;
            r_pairs   <= n_pairs;
            r_held_a  <= n_held_a;
            r_held_b  <= n_held_b;
            r_saved_a <= n_saved_a;
            r_saved_b <= n_saved_b;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_m_tvalid <= 1'b0;
        end else if (s1_advance) begin
            o_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            o_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            o_m_tdata <= {5'b0, diff, finished, took_b, took_a};
        end
    end

endmodule

`default_nettype wire
